// ===== hdl/ansi_color_escape_to_text_cells_top_macros.svh =====
// Assertion macros used by the checker file of the color escape block.
`ifndef ANSI_COLOR_ESCAPE_TO_TEXT_CELLS_TOP_MACROS_SVH
`define ANSI_COLOR_ESCAPE_TO_TEXT_CELLS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/acet_pkg.sv =====
// Shared types, constants and helper functions of the color escape block.
package acet_pkg;

    localparam int MAX_BODY_DEF = 31;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LB   = 8'h5B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    localparam logic [3:0] INITIAL_FG_RST = 4'h2;
    localparam logic [3:0] INITIAL_BG_RST = 4'h0;
    localparam logic [3:0] SGR_FG_RST     = 4'h7;
    localparam logic [3:0] SGR_BG_RST     = 4'h0;

    typedef enum logic [1:0] {
        REG_INITIAL_FG = 2'd0,
        REG_INITIAL_BG = 2'd1,
        REG_SGR_FG     = 2'd2,
        REG_SGR_BG     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [3:0] initial_fg;
        logic [3:0] initial_bg;
        logic [3:0] sgr_fg;
        logic [3:0] sgr_bg;
    } cfg_t;

    // Source of the character loaded into the output register
    typedef enum logic [2:0] {
        SEL_ESC      = 3'd0,
        SEL_LB       = 3'd1,
        SEL_HELD     = 3'd2,
        SEL_BYTE_IN  = 3'd3,
        SEL_BYTE_REG = 3'd4
    } cell_sel_t;

    // Cells one byte causes, in emission order:
    // ESC, '[', held bytes, the byte itself, a trailing ESC
    typedef struct packed {
        logic pre_esc;
        logic pre_lb;
        logic emit_b;
        logic post_esc;
    } plan_t;

    typedef struct packed {
        logic      accept;
        logic      load;
        cell_sel_t sel;
        logic      last;
        logic      idx_inc;
    } ctrl_cmd_t;

    typedef struct packed {
        plan_t plan_now;
        plan_t plan_held;
        logic  held_any;
        logic  held_more;
        logic  out_free;
    } dp_status_t;

    // ANSI color order to PC palette order
    function automatic logic [2:0] pc_map(input logic [2:0] ansi);
        logic [2:0] pc;
        case (ansi)
            3'd0:    pc = 3'd0;
            3'd1:    pc = 3'd4;
            3'd2:    pc = 3'd2;
            3'd3:    pc = 3'd6;
            3'd4:    pc = 3'd1;
            3'd5:    pc = 3'd5;
            3'd6:    pc = 3'd3;
            3'd7:    pc = 3'd7;
            default: pc = 3'd0;
        endcase
        return pc;
    endfunction

endpackage

// ===== hdl/acet_in_if.sv =====
// Text byte channel: valid/ready handshake carrying one byte and its end mark.
interface acet_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       buffer_end;

    modport source (output valid, output char_in, output buffer_end, input ready);
    modport sink   (input valid, input char_in, input buffer_end, output ready);
endinterface

// ===== hdl/acet_out_if.sv =====
// Character cell channel: valid/ready handshake carrying one colored cell.
interface acet_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic [3:0] fg_out;
    logic [3:0] bg_out;
    logic       run_end;

    modport source (output valid, output char_out, output fg_out, output bg_out,
                    output run_end, input ready);
    modport sink   (input valid, input char_out, input fg_out, input bg_out,
                    input run_end, output ready);
endinterface

// ===== hdl/acet_cfg.sv =====
// APB register file holding the four color configuration registers.
module acet_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [acet_pkg::ADDR_W-1:0] paddr,
    input  logic [acet_pkg::DATA_W-1:0] pwdata,
    output logic [acet_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output acet_pkg::cfg_t             cfg
);

    acet_pkg::cfg_t     cfg_reg;
    acet_pkg::cfg_t     cfg_next;
    acet_pkg::reg_idx_t idx;
    logic [3:0]         rd_val;
    logic               wr_en;

    assign idx    = acet_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        rd_val   = 4'h0;
        case (idx)
            acet_pkg::REG_INITIAL_FG:
            begin
                rd_val = cfg_reg.initial_fg;
                if (wr_en)
                begin
                    cfg_next.initial_fg = pwdata[3:0];
                end
            end
            acet_pkg::REG_INITIAL_BG:
            begin
                rd_val = cfg_reg.initial_bg;
                if (wr_en)
                begin
                    cfg_next.initial_bg = pwdata[3:0];
                end
            end
            acet_pkg::REG_SGR_FG:
            begin
                rd_val = cfg_reg.sgr_fg;
                if (wr_en)
                begin
                    cfg_next.sgr_fg = pwdata[3:0];
                end
            end
            acet_pkg::REG_SGR_BG:
            begin
                rd_val = cfg_reg.sgr_bg;
                if (wr_en)
                begin
                    cfg_next.sgr_bg = pwdata[3:0];
                end
            end
            default:
            begin
                rd_val = 4'h0;
            end
        endcase
    end

    assign prdata = {{(acet_pkg::DATA_W-4){1'b0}}, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_fg <= acet_pkg::INITIAL_FG_RST;
            cfg_reg.initial_bg <= acet_pkg::INITIAL_BG_RST;
            cfg_reg.sgr_fg     <= acet_pkg::SGR_FG_RST;
            cfg_reg.sgr_bg     <= acet_pkg::SGR_BG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/acet_ctrl.sv =====
// Emission sequencer: takes bytes and steps through the cells each one causes.
module acet_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  acet_pkg::dp_status_t   status,
    output acet_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_RUN  = 5'b00001,
        ST_LB   = 5'b00010,
        ST_HELD = 5'b00100,
        ST_BYTE = 5'b01000,
        ST_POST = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t nxt;

    // First remaining cell kind decides the next state; none left means RUN
    function automatic state_t pick(input logic lb, input logic held,
                                    input logic byt, input logic post);
        state_t s;
        if (lb)
        begin
            s = ST_LB;
        end
        else if (held)
        begin
            s = ST_HELD;
        end
        else if (byt)
        begin
            s = ST_BYTE;
        end
        else if (post)
        begin
            s = ST_POST;
        end
        else
        begin
            s = ST_RUN;
        end
        return s;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        nxt         = ST_RUN;
        in_ready    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.load    = 1'b0;
        cmd.sel     = acet_pkg::SEL_ESC;
        cmd.idx_inc = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.accept = 1'b1;
                    if (status.plan_now.pre_esc)
                    begin
                        cmd.load = 1'b1;
                        cmd.sel  = acet_pkg::SEL_ESC;
                        nxt = status.plan_now.pre_lb ? ST_LB :
                              pick(1'b0, 1'b0, status.plan_now.emit_b,
                                   status.plan_now.post_esc);
                    end
                    else if (status.plan_now.emit_b)
                    begin
                        cmd.load = 1'b1;
                        cmd.sel  = acet_pkg::SEL_BYTE_IN;
                        nxt = pick(1'b0, 1'b0, 1'b0, status.plan_now.post_esc);
                    end
                    else if (status.plan_now.post_esc)
                    begin
                        cmd.load = 1'b1;
                        cmd.sel  = acet_pkg::SEL_ESC;
                        nxt = ST_RUN;
                    end
                    state_next = nxt;
                end
            end
            ST_LB:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = acet_pkg::SEL_LB;
                    nxt = pick(1'b0, status.held_any, status.plan_held.emit_b,
                               status.plan_held.post_esc);
                    state_next = nxt;
                end
            end
            ST_HELD:
            begin
                if (status.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.sel     = acet_pkg::SEL_HELD;
                    cmd.idx_inc = 1'b1;
                    nxt = pick(1'b0, status.held_more, status.plan_held.emit_b,
                               status.plan_held.post_esc);
                    state_next = nxt;
                end
            end
            ST_BYTE:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = acet_pkg::SEL_BYTE_REG;
                    nxt = pick(1'b0, 1'b0, 1'b0, status.plan_held.post_esc);
                    state_next = nxt;
                end
            end
            ST_POST:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = acet_pkg::SEL_ESC;
                    nxt = ST_RUN;
                    state_next = nxt;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
        cmd.last = cmd.load && (nxt == ST_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/acet_dp.sv =====
// Escape parser state, held body bytes and the registered output cell.
module acet_dp #(
    parameter int MAX_BODY = acet_pkg::MAX_BODY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  acet_pkg::cfg_t       cfg,
    input  logic [7:0]           char_in,
    input  logic                 buffer_end,
    input  acet_pkg::ctrl_cmd_t  cmd,
    output acet_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           char_out,
    output logic [3:0]           fg_out,
    output logic [3:0]           bg_out,
    output logic                 run_end
);

    localparam int HCW = $clog2(MAX_BODY + 1);
    localparam int AW  = $clog2(MAX_BODY);
    localparam logic [HCW-1:0] MAX_CNT = HCW'(MAX_BODY);

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_ESC   = 4'b0010,
        M_BODY  = 4'b0100,
        M_DRAIN = 4'b1000
    } mode_t;

    mode_t            mode_reg,     mode_next;
    logic             buf_start_reg, buf_start_next;
    logic [3:0]       act_fg_reg,   act_fg_next;
    logic [3:0]       act_bg_reg,   act_bg_next;
    logic [3:0]       pend_fg_reg,  pend_fg_next;
    logic [3:0]       pend_bg_reg,  pend_bg_next;
    logic [7:0]       pval_reg,     pval_next;
    logic [1:0]       pflag_reg,    pflag_next;
    logic [HCW-1:0]   count_reg,    count_next;
    acet_pkg::plan_t  plan_reg,     plan_next;
    logic [HCW-1:0]   held_n_reg,   held_n_next;
    logic [HCW-1:0]   idx_reg,      idx_next;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]       mem [MAX_BODY];
    logic [7:0]       rd_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       char_reg;
    logic [3:0]       fg_reg;
    logic [3:0]       bg_reg;
    logic             run_end_reg;

    logic [3:0]       act_fg_e, act_bg_e, pend_fg_e, pend_bg_e;
    logic [3:0]       apl_fg, apl_bg;
    logic [11:0]      acc;
    logic [7:0]       digit_sat;
    logic             is_digit;
    logic             wr_en;
    logic [7:0]       cell_char;
    acet_pkg::plan_t  plan_now;

    // A new buffer starts from the configured colors
    assign act_fg_e  = buf_start_reg ? cfg.initial_fg : act_fg_reg;
    assign act_bg_e  = buf_start_reg ? cfg.initial_bg : act_bg_reg;
    assign pend_fg_e = buf_start_reg ? cfg.initial_fg : pend_fg_reg;
    assign pend_bg_e = buf_start_reg ? cfg.initial_bg : pend_bg_reg;

    assign acc = ({4'b0, pval_reg} << 3) + ({4'b0, pval_reg} << 1) + {8'b0, char_in[3:0]};
    assign digit_sat = (acc > 12'd255) ? 8'hFF : acc[7:0];
    assign is_digit  = char_in inside {[acet_pkg::CH_0:acet_pkg::CH_9]};

    // Apply the parameter collected so far to the pending colors
    always_comb
    begin
        apl_fg = pend_fg_e;
        apl_bg = pend_bg_e;
        if (pflag_reg[0])
        begin
            if (pval_reg inside {[8'd30:8'd37]})
            begin
                apl_fg = {1'b0, acet_pkg::pc_map(3'(pval_reg - 8'd30))};
            end
            else if (pval_reg inside {[8'd90:8'd97]})
            begin
                apl_fg = {1'b1, acet_pkg::pc_map(3'(pval_reg - 8'd90))};
            end
            else if (pval_reg inside {[8'd40:8'd47]})
            begin
                apl_bg = {1'b0, acet_pkg::pc_map(3'(pval_reg - 8'd40))};
            end
            else if (pval_reg inside {[8'd100:8'd107]})
            begin
                apl_bg = {1'b1, acet_pkg::pc_map(3'(pval_reg - 8'd100))};
            end
            else if (pval_reg == 8'd0)
            begin
                apl_fg = cfg.sgr_fg;
                apl_bg = cfg.sgr_bg;
            end
        end
    end

    // Parser update and cell plan for the byte on the input
    always_comb
    begin
        mode_next      = mode_reg;
        buf_start_next = buf_start_reg;
        act_fg_next    = act_fg_reg;
        act_bg_next    = act_bg_reg;
        pend_fg_next   = pend_fg_reg;
        pend_bg_next   = pend_bg_reg;
        pval_next      = pval_reg;
        pflag_next     = pflag_reg;
        count_next     = count_reg;
        held_n_next    = '0;
        wr_en          = 1'b0;
        plan_now       = '0;

        act_fg_next  = act_fg_e;
        act_bg_next  = act_bg_e;
        pend_fg_next = pend_fg_e;
        pend_bg_next = pend_bg_e;
        if (!cmd.accept)
        begin
            act_fg_next  = act_fg_reg;
            act_bg_next  = act_bg_reg;
            pend_fg_next = pend_fg_reg;
            pend_bg_next = pend_bg_reg;
        end

        case (mode_reg)
            M_IDLE:
            begin
                if (char_in == acet_pkg::CH_NUL)
                begin
                    mode_next = M_DRAIN;
                end
                else if (char_in == acet_pkg::CH_ESC)
                begin
                    mode_next = M_ESC;
                end
                else
                begin
                    plan_now.emit_b = 1'b1;
                end
            end
            M_ESC:
            begin
                if (char_in == acet_pkg::CH_LB)
                begin
                    mode_next    = M_BODY;
                    pend_fg_next = act_fg_e;
                    pend_bg_next = act_bg_e;
                    pval_next    = '0;
                    pflag_next   = '0;
                    count_next   = '0;
                end
                else
                begin
                    plan_now.pre_esc = 1'b1;
                    mode_next = M_IDLE;
                    if (char_in == acet_pkg::CH_NUL)
                    begin
                        mode_next = M_DRAIN;
                    end
                    else if (char_in == acet_pkg::CH_ESC)
                    begin
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        plan_now.emit_b = 1'b1;
                    end
                end
            end
            M_BODY:
            begin
                if (char_in == acet_pkg::CH_NUL)
                begin
                    plan_now.pre_esc = 1'b1;
                    plan_now.pre_lb  = 1'b1;
                    held_n_next = count_reg;
                    mode_next   = M_DRAIN;
                    pval_next   = '0;
                    pflag_next  = '0;
                    count_next  = '0;
                end
                else if (char_in == acet_pkg::CH_M)
                begin
                    act_fg_next  = apl_fg;
                    act_bg_next  = apl_bg;
                    pend_fg_next = apl_fg;
                    pend_bg_next = apl_bg;
                    mode_next    = M_IDLE;
                    pval_next    = '0;
                    pflag_next   = '0;
                    count_next   = '0;
                end
                else if (count_reg >= MAX_CNT)
                begin
                    // Body overflow: flush, then treat the byte as plain text
                    plan_now.pre_esc = 1'b1;
                    plan_now.pre_lb  = 1'b1;
                    held_n_next = count_reg;
                    pval_next   = '0;
                    pflag_next  = '0;
                    count_next  = '0;
                    mode_next   = M_IDLE;
                    if (char_in == acet_pkg::CH_ESC)
                    begin
                        mode_next = M_ESC;
                    end
                    else
                    begin
                        plan_now.emit_b = 1'b1;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + HCW'(1);
                    if (char_in == acet_pkg::CH_SEMI)
                    begin
                        pend_fg_next = apl_fg;
                        pend_bg_next = apl_bg;
                        pval_next    = '0;
                        pflag_next   = '0;
                    end
                    else if (is_digit)
                    begin
                        pflag_next[0] = 1'b1;
                        if (!pflag_reg[1])
                        begin
                            pval_next = digit_sat;
                        end
                    end
                    else
                    begin
                        pflag_next = 2'b11;
                    end
                end
            end
            M_DRAIN:
            begin
                mode_next = M_DRAIN;
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase

        if (buffer_end)
        begin
            if (mode_next == M_ESC)
            begin
                plan_now.post_esc = 1'b1;
            end
            else if (mode_next == M_BODY)
            begin
                // Open body at the end: flush it, the byte itself goes last
                plan_now.pre_esc = 1'b1;
                plan_now.pre_lb  = 1'b1;
                if (mode_reg == M_BODY)
                begin
                    held_n_next = count_reg;
                    plan_now.emit_b = 1'b1;
                end
            end
            mode_next      = M_IDLE;
            pval_next      = '0;
            pflag_next     = '0;
            count_next     = '0;
            buf_start_next = 1'b1;
        end
        else
        begin
            buf_start_next = 1'b0;
        end

        if (!cmd.accept)
        begin
            mode_next      = mode_reg;
            buf_start_next = buf_start_reg;
            pval_next      = pval_reg;
            pflag_next     = pflag_reg;
            count_next     = count_reg;
            act_fg_next    = act_fg_reg;
            act_bg_next    = act_bg_reg;
            pend_fg_next   = pend_fg_reg;
            pend_bg_next   = pend_bg_reg;
            wr_en          = 1'b0;
        end
    end

    assign plan_next = cmd.accept ? plan_now : plan_reg;
    assign idx_next  = cmd.accept  ? '0 :
                       cmd.idx_inc ? idx_reg + HCW'(1) : idx_reg;

    assign status.plan_now  = plan_now;
    assign status.plan_held = plan_reg;
    assign status.held_any  = (held_n_reg != '0);
    assign status.held_more = ((idx_reg + HCW'(1)) != held_n_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.sel)
            acet_pkg::SEL_ESC:      cell_char = acet_pkg::CH_ESC;
            acet_pkg::SEL_LB:       cell_char = acet_pkg::CH_LB;
            acet_pkg::SEL_HELD:     cell_char = rd_reg;
            acet_pkg::SEL_BYTE_IN:  cell_char = char_in;
            acet_pkg::SEL_BYTE_REG: cell_char = byte_reg;
            default:                cell_char = acet_pkg::CH_ESC;
        endcase
    end

    assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            buf_start_reg <= 1'b1;
            act_fg_reg    <= acet_pkg::INITIAL_FG_RST;
            act_bg_reg    <= acet_pkg::INITIAL_BG_RST;
            pend_fg_reg   <= acet_pkg::INITIAL_FG_RST;
            pend_bg_reg   <= acet_pkg::INITIAL_BG_RST;
            pval_reg      <= '0;
            pflag_reg     <= '0;
            count_reg     <= '0;
            plan_reg      <= '0;
            held_n_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            buf_start_reg <= buf_start_next;
            act_fg_reg    <= act_fg_next;
            act_bg_reg    <= act_bg_next;
            pend_fg_reg   <= pend_fg_next;
            pend_bg_reg   <= pend_bg_next;
            pval_reg      <= pval_next;
            pflag_reg     <= pflag_next;
            count_reg     <= count_next;
            plan_reg      <= plan_next;
            held_n_reg    <= cmd.accept ? held_n_next : held_n_reg;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Body store; the read runs one index ahead of the emitter
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= char_in;
        end
        rd_reg <= mem[idx_next[AW-1:0]];
        if (cmd.accept)
        begin
            byte_reg <= char_in;
        end
        if (cmd.load)
        begin
            char_reg    <= cell_char;
            fg_reg      <= cmd.accept ? act_fg_e : act_fg_reg;
            bg_reg      <= cmd.accept ? act_bg_e : act_bg_reg;
            run_end_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign fg_out    = fg_reg;
    assign bg_out    = bg_reg;
    assign run_end   = run_end_reg;

endmodule

// ===== hdl/ansi_color_escape_to_text_cells_top.sv =====
// Top level: SGR color escapes in a byte stream to colored character cells.
// A byte's first cell, if it causes any, is loaded into the output register as it is accepted.
// Throughput: one byte per cycle for plain text and escape bodies unless the output
//   stalls; a byte that causes more than one cell holds the input until its last cell
//   is loaded, the sequencer emitting one cell a cycle while the output takes them.
// Reset (rst_n low, asynchronous): registers take their defaults, parser goes idle,
//   colors load from initial_fg/initial_bg on the first byte of every buffer.
module ansi_color_escape_to_text_cells_top #(
    parameter int MAX_BODY = acet_pkg::MAX_BODY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    acet_in_if.sink                     text_in,
    acet_out_if.source                  cell_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [acet_pkg::ADDR_W-1:0] paddr,
    input  logic [acet_pkg::DATA_W-1:0] pwdata,
    output logic [acet_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    // Configuration registers; the user must write them only while the stream is
    // quiet, so the parser samples them directly; the block does not enforce this.
    acet_pkg::cfg_t       cfg;

    // Controller to datapath: which cell to load next, when to take a beat.
    acet_pkg::ctrl_cmd_t  cmd;

    // Datapath to controller: cell plan of the current byte, the latched plan of
    // the byte being expanded, held-byte progress and output slot status.
    acet_pkg::dp_status_t status;

    acet_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: takes a beat only when the output slot is free and no cells
    // of the previous byte remain; then walks ESC, '[', held bytes, the byte
    // and a trailing ESC as the plan asks.
    acet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Parser, body store and output register. The output register decouples
    // the sides: a new beat is taken in the same cycle the waiting cell leaves.
    acet_dp #(
        .MAX_BODY (MAX_BODY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .char_in    (text_in.char_in),
        .buffer_end (text_in.buffer_end),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (cell_out.valid),
        .out_ready  (cell_out.ready),
        .char_out   (cell_out.char_out),
        .fg_out     (cell_out.fg_out),
        .bg_out     (cell_out.bg_out),
        .run_end    (cell_out.run_end)
    );

endmodule

// ===== hdl/acet_chk.sv =====
// Port-level checker for the color escape block, bound to the top level.
`include "ansi_color_escape_to_text_cells_top_macros.svh"

module acet_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_out,
    input logic [3:0] fg_out,
    input logic [3:0] bg_out,
    input logic       run_end
);

    `ACET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_out) && $stable(fg_out) && $stable(bg_out) && $stable(run_end), "stalled cell changed")
    `ACET_ASSERT_NOW(a_no_take_on_stall, out_valid && !out_ready, !in_ready, "byte taken while cell stalled")
    `ACET_ASSERT_NOW(a_no_take_mid_run, out_valid && !run_end, !in_ready, "byte taken before run ended")
    `ACET_ASSERT_NEXT(a_run_continues, out_valid && !run_end, out_valid, "run broke off")
    `ACET_ASSERT_NOW(a_rise_from_beat, $rose(out_valid), $past(in_valid && in_ready), "cell without a beat")

endmodule

bind ansi_color_escape_to_text_cells_top acet_chk u_acet_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .out_valid (cell_out.valid),
    .out_ready (cell_out.ready),
    .char_out  (cell_out.char_out),
    .fg_out    (cell_out.fg_out),
    .bg_out    (cell_out.bg_out),
    .run_end   (cell_out.run_end)
);

// ===== verif/ansi_color_escape_to_text_cells_top_tb.sv =====
// Self-checking testbench for the ANSI color escape to text cell converter.
module ansi_color_escape_to_text_cells_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BODY_MAX       = acet_pkg::MAX_BODY_DEF;
    localparam int ITEMS_PER_LOAD = 75;
    localparam int IDLE_PCT       = 17;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = BODY_MAX + 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT    = 50;

    // SGR parameter code bases; each covers eight colors
    localparam int SGR_FG        = 30;
    localparam int SGR_BG        = 40;
    localparam int SGR_FG_BRIGHT = 90;
    localparam int SGR_BG_BRIGHT = 100;
    localparam int SGR_SPAN      = 7;

    // ANSI color index to PC palette index, three bits per entry, index 0 at the bottom
    localparam logic [23:0] PC_ORDER = {3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd0};

    typedef enum logic [1:0] {
        PM_IDLE  = 2'd0,
        PM_ESC   = 2'd1,
        PM_BODY  = 2'd2,
        PM_DRAIN = 2'd3
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] fg;
        logic [3:0] bg;
        logic       run_end;
    } cell_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [acet_pkg::ADDR_W-1:0]   paddr;
    logic [acet_pkg::DATA_W-1:0]   pwdata;
    logic [acet_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    acet_in_if  text_if ();
    acet_out_if cell_if ();

    ansi_color_escape_to_text_cells_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_if),
        .cell_out (cell_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: register copy and parser state
    // ------------------------------------------------------------------
    acet_pkg::cfg_t shadow_cfg;
    parse_mode_t  mode;
    logic [3:0]   act_fg, act_bg, pend_fg, pend_bg;
    logic [7:0]   num_val;
    logic [1:0]   num_flags;   // bit0: parameter has content, bit1: digits ended
    logic [7:0]   held [BODY_MAX];
    int           held_n;
    bit           new_buffer;

    text_beat_t   bytes_to_send [$];
    cell_t        cells_due [$];
    int           bytes_queued;
    int unsigned  mismatches;

    // Pacing controls shared between the sequence and the two handshake processes
    bit           send_steady;
    bit           recv_steady;
    int           hold_ask;
    int           hold_seen;
    int           hold_left;
    int           quiet_cycles;

    function automatic logic [2:0] ansi_to_pc(input int ansi);
        return PC_ORDER[3*ansi +: 3];
    endfunction

    // Append one cell in the current colors
    function automatic void add_cell(input logic [7:0] ch);
        cell_t c;
        c.ch      = ch;
        c.fg      = act_fg;
        c.bg      = act_bg;
        c.run_end = 1'b0;
        cells_due.push_back(c);
    endfunction

    // Close the current parameter and fold it into the pending colors
    function automatic void close_param();
        int v;
        v = num_val;
        if (num_flags[0])
        begin
            if (v >= SGR_FG && v <= SGR_FG + SGR_SPAN)
                pend_fg = {1'b0, ansi_to_pc(v - SGR_FG)};
            else if (v >= SGR_FG_BRIGHT && v <= SGR_FG_BRIGHT + SGR_SPAN)
                pend_fg = {1'b1, ansi_to_pc(v - SGR_FG_BRIGHT)};
            else if (v >= SGR_BG && v <= SGR_BG + SGR_SPAN)
                pend_bg = {1'b0, ansi_to_pc(v - SGR_BG)};
            else if (v >= SGR_BG_BRIGHT && v <= SGR_BG_BRIGHT + SGR_SPAN)
                pend_bg = {1'b1, ansi_to_pc(v - SGR_BG_BRIGHT)};
            else if (v == 0)
            begin
                pend_fg = shadow_cfg.sgr_fg;
                pend_bg = shadow_cfg.sgr_bg;
            end
        end
        num_val   = '0;
        num_flags = '0;
    endfunction

    // Give up on a body: replay ESC, '[' and the held bytes as plain cells
    function automatic void flush_body();
        add_cell(acet_pkg::CH_ESC);
        add_cell(acet_pkg::CH_LB);
        for (int i = 0; i < held_n; i++)
            add_cell(held[i]);
        held_n    = 0;
        num_val   = '0;
        num_flags = '0;
        mode      = PM_IDLE;
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == acet_pkg::CH_NUL)
            mode = PM_DRAIN;
        else if (b == acet_pkg::CH_ESC)
            mode = PM_ESC;
        else
            add_cell(b);
    endfunction

    // Work out the cells one accepted byte causes and queue them
    function automatic void render_byte(input logic [7:0] b, input logic last);
        int first;
        int v;
        first = cells_due.size();
        if (new_buffer)
        begin
            act_fg     = shadow_cfg.initial_fg;
            pend_fg    = shadow_cfg.initial_fg;
            act_bg     = shadow_cfg.initial_bg;
            pend_bg    = shadow_cfg.initial_bg;
            mode       = PM_IDLE;
            num_val    = '0;
            num_flags  = '0;
            held_n     = 0;
            new_buffer = 1'b0;
        end
        case (mode)
            PM_IDLE:
                take_plain(b);
            PM_ESC:
                if (b == acet_pkg::CH_LB)
                begin
                    mode      = PM_BODY;
                    pend_fg   = act_fg;
                    pend_bg   = act_bg;
                    num_val   = '0;
                    num_flags = '0;
                    held_n    = 0;
                end
                else
                begin
                    mode = PM_IDLE;
                    add_cell(acet_pkg::CH_ESC);
                    take_plain(b);
                end
            PM_BODY:
                if (b == acet_pkg::CH_NUL)
                begin
                    flush_body();
                    mode = PM_DRAIN;
                end
                else if (b == acet_pkg::CH_M)
                begin
                    close_param();
                    act_fg = pend_fg;
                    act_bg = pend_bg;
                    held_n = 0;
                    mode   = PM_IDLE;
                end
                else if (held_n >= BODY_MAX)
                begin
                    // body too long: replay it, then treat this byte as text
                    flush_body();
                    take_plain(b);
                end
                else
                begin
                    held[held_n] = b;
                    held_n++;
                    if (b == acet_pkg::CH_SEMI)
                        close_param();
                    else if (b >= acet_pkg::CH_0 && b <= acet_pkg::CH_9)
                    begin
                        num_flags[0] = 1'b1;
                        if (!num_flags[1])
                        begin
                            v = num_val * 10 + (b - acet_pkg::CH_0);
                            num_val = (v > 255) ? 8'd255 : 8'(v);
                        end
                    end
                    else
                        num_flags = 2'b11;
                end
            default:
                ;   // draining after NUL: drop the byte
        endcase
        if (last)
        begin
            // a sequence still open at the buffer end is replayed as text
            if (mode == PM_ESC)
                add_cell(acet_pkg::CH_ESC);
            else if (mode == PM_BODY)
                flush_body();
            mode       = PM_IDLE;
            num_val    = '0;
            num_flags  = '0;
            held_n     = 0;
            new_buffer = 1'b1;
        end
        if (cells_due.size() > first)
            cells_due[cells_due.size()-1].run_end = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Byte driver: present the next pending beat, idle at random
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t beat;
        if (!rst_n)
        begin
            text_if.valid      <= 1'b0;
            text_if.char_in    <= '0;
            text_if.buffer_end <= 1'b0;
        end
        else if (!text_if.valid || text_if.ready)
        begin
            if (bytes_to_send.size() != 0 &&
                (send_steady || $urandom_range(99) >= IDLE_PCT))
            begin
                beat = bytes_to_send.pop_front();
                text_if.valid      <= 1'b1;
                text_if.char_in    <= beat.ch;
                text_if.buffer_end <= beat.last;
            end
            else
                text_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Cell receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_if.ready <= 1'b0;
            hold_left     <= 0;
            hold_seen     <= 0;
        end
        else if (hold_left != 0)
        begin
            cell_if.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_ask != hold_seen)
        begin
            cell_if.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_seen     <= hold_ask;
        end
        else
            cell_if.ready <= recv_steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted byte, check every accepted cell.
    // Prediction runs first; a cell never leaves in the cycle its byte enters.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cell_t want;
        if (rst_n)
        begin
            if (text_if.valid && text_if.ready)
                render_byte(text_if.char_in, text_if.buffer_end);
            if (cell_if.valid && cell_if.ready)
            begin
                if (cells_due.size() == 0)
                    report_mismatch("unexpected cell char", cell_if.char_out, 0);
                else
                begin
                    want = cells_due.pop_front();
                    if (cell_if.char_out !== want.ch)
                        report_mismatch("char_out", cell_if.char_out, want.ch);
                    if (cell_if.fg_out !== want.fg)
                        report_mismatch("fg_out", cell_if.fg_out, want.fg);
                    if (cell_if.bg_out !== want.bg)
                        report_mismatch("bg_out", cell_if.bg_out, want.bg);
                    if (cell_if.run_end !== want.run_end)
                        report_mismatch("run_end", cell_if.run_end, want.run_end);
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (text_if.valid && text_if.ready) || (cell_if.valid && cell_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d cells outstanding",
                     quiet_cycles, cells_due.size());
            $display("ansi_color_escape_to_text_cells_top_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one buffer; the final byte carries the end mark
    task automatic send_buffer(input logic [7:0] seq [$]);
        text_beat_t beat;
        foreach (seq[i])
        begin
            beat.ch   = seq[i];
            beat.last = (i == seq.size() - 1);
            bytes_to_send.push_back(beat);
        end
        bytes_queued += seq.size();
    endtask

    // Build a buffer of mixed segments: mostly text and well-formed SGR
    // sequences, with broken escapes, NUL cuts, overlong bodies and noise.
    task automatic send_random_buffer();
        logic [7:0] seq [$];
        int         segs;
        int         kind;
        int         v;
        logic [7:0] b;
        bit         cut;
        segs = $urandom_range(1, 5);
        cut  = 1'b0;
        for (int s = 0; s < segs && !cut; s++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    b = $urandom_range(1, 255);
                    seq.push_back(b == acet_pkg::CH_ESC ? 8'h20 : b);
                end
            end
            else if (kind < 75)
            begin
                seq.push_back(acet_pkg::CH_ESC);
                seq.push_back(acet_pkg::CH_LB);
                v = $urandom_range(0, 3);
                for (int p = 0; p < v; p++)
                begin
                    int code;
                    if (p > 0)
                        seq.push_back(acet_pkg::CH_SEMI);
                    case ($urandom_range(0, 7))
                        0:       code = 0;
                        1:       code = SGR_FG + $urandom_range(0, SGR_SPAN);
                        2:       code = SGR_FG_BRIGHT + $urandom_range(0, SGR_SPAN);
                        3:       code = SGR_BG + $urandom_range(0, SGR_SPAN);
                        4:       code = SGR_BG_BRIGHT + $urandom_range(0, SGR_SPAN);
                        5:       code = $urandom_range(0, 999);
                        6:       code = -1;   // empty parameter
                        default: code = -2;   // digits cut short by a stray byte
                    endcase
                    if (code >= 0)
                    begin
                        if (code >= 100)
                            seq.push_back(8'(acet_pkg::CH_0 + code / 100));
                        if (code >= 10)
                            seq.push_back(8'(acet_pkg::CH_0 + (code / 10) % 10));
                        seq.push_back(8'(acet_pkg::CH_0 + code % 10));
                    end
                    else if (code == -2)
                    begin
                        if ($urandom_range(0, 1))
                            seq.push_back(8'(acet_pkg::CH_0 + $urandom_range(0, 9)));
                        b = $urandom_range(1, 255);
                        seq.push_back(b == acet_pkg::CH_M ? 8'h78 : b);
                    end
                end
                seq.push_back(acet_pkg::CH_M);
            end
            else if (kind < 82)
            begin
                // ESC not followed by '['
                seq.push_back(acet_pkg::CH_ESC);
                b = $urandom_range(1, 255);
                seq.push_back(b == acet_pkg::CH_LB ? 8'h5A : b);
            end
            else if (kind < 88)
            begin
                // body broken by NUL; the rest of the buffer is dropped
                seq.push_back(acet_pkg::CH_ESC);
                seq.push_back(acet_pkg::CH_LB);
                repeat ($urandom_range(0, 4))
                    seq.push_back(8'(acet_pkg::CH_0 + $urandom_range(0, 9)));
                seq.push_back(acet_pkg::CH_NUL);
                repeat ($urandom_range(0, 3))
                    seq.push_back(8'($urandom_range(0, 255)));
                cut = 1'b1;
            end
            else if (kind < 92)
            begin
                // body longer than the hold store
                seq.push_back(acet_pkg::CH_ESC);
                seq.push_back(acet_pkg::CH_LB);
                repeat (BODY_MAX + $urandom_range(1, 3))
                    seq.push_back($urandom_range(0, 3) == 0 ? acet_pkg::CH_SEMI
                                  : 8'(acet_pkg::CH_0 + $urandom_range(0, 9)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        // sometimes leave an escape open at the buffer end
        if (!cut && $urandom_range(0, 99) < 15)
        begin
            seq.push_back(acet_pkg::CH_ESC);
            if ($urandom_range(0, 1))
            begin
                seq.push_back(acet_pkg::CH_LB);
                seq.push_back(8'(acet_pkg::CH_0 + $urandom_range(0, 9)));
            end
        end
        send_buffer(seq);
    endtask

    task automatic send_random_load();
        int start;
        start = bytes_queued;
        while (bytes_queued - start < ITEMS_PER_LOAD)
            send_random_buffer();
    endtask

    // Wait until every byte went in and every cell came out, then let the block settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (bytes_to_send.size() != 0 || text_if.valid || cells_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Two-phase register write; the shadow copy follows at the write edge
    task automatic write_reg(input acet_pkg::reg_idx_t idx, input logic [3:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= acet_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= acet_pkg::DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            acet_pkg::REG_INITIAL_FG: shadow_cfg.initial_fg = val;
            acet_pkg::REG_INITIAL_BG: shadow_cfg.initial_bg = val;
            acet_pkg::REG_SGR_FG:     shadow_cfg.sgr_fg     = val;
            acet_pkg::REG_SGR_BG:     shadow_cfg.sgr_bg     = val;
            default:                  ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_colors(input logic [3:0] ifg, input logic [3:0] ibg,
                               input logic [3:0] sfg, input logic [3:0] sbg);
        write_reg(acet_pkg::REG_INITIAL_FG, ifg);
        write_reg(acet_pkg::REG_INITIAL_BG, ibg);
        write_reg(acet_pkg::REG_SGR_FG, sfg);
        write_reg(acet_pkg::REG_SGR_BG, sbg);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] seq [$];

        // drive everything to a known value before the first edge
        text_if.valid      = 1'b0;
        text_if.char_in    = '0;
        text_if.buffer_end = 1'b0;
        cell_if.ready      = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        shadow_cfg.initial_fg = acet_pkg::INITIAL_FG_RST;
        shadow_cfg.initial_bg = acet_pkg::INITIAL_BG_RST;
        shadow_cfg.sgr_fg     = acet_pkg::SGR_FG_RST;
        shadow_cfg.sgr_bg     = acet_pkg::SGR_BG_RST;
        mode         = PM_IDLE;
        act_fg       = acet_pkg::INITIAL_FG_RST;
        act_bg       = acet_pkg::INITIAL_BG_RST;
        pend_fg      = acet_pkg::INITIAL_FG_RST;
        pend_bg      = acet_pkg::INITIAL_BG_RST;
        num_val      = '0;
        num_flags    = '0;
        held_n       = 0;
        new_buffer   = 1'b1;
        bytes_queued = 0;
        mismatches   = 0;
        send_steady  = 1'b0;
        recv_steady  = 1'b0;
        hold_ask     = 0;
        quiet_cycles = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset colors.
        // Single top-value byte that opens and closes its own buffer.
        seq = {8'hFF};
        send_buffer(seq);
        // Bright foreground and background, ESC without '[', ESC left open at the end.
        seq = {8'h01, acet_pkg::CH_ESC, acet_pkg::CH_LB, "9", "7", acet_pkg::CH_SEMI,
               "1", "0", "7", acet_pkg::CH_M,
               "x", acet_pkg::CH_ESC, "q", acet_pkg::CH_ESC};
        send_buffer(seq);
        // Empty parameter plus a digitless one (acts as code zero), then a body
        // broken by NUL; the trailing byte is dropped.
        seq = {acet_pkg::CH_ESC, acet_pkg::CH_LB, acet_pkg::CH_SEMI, "a", acet_pkg::CH_M,
               "A", acet_pkg::CH_ESC, acet_pkg::CH_LB, "3", acet_pkg::CH_NUL, "7"};
        send_buffer(seq);
        wait_drained();

        // Top values everywhere
        load_colors(4'hF, 4'hF, 4'hF, 4'hF);
        send_random_load();
        wait_drained();

        // Bottom values, with both sides running flat out
        load_colors(4'h0, 4'h0, 4'h0, 4'h0);
        send_steady = 1'b1;
        recv_steady = 1'b1;
        send_random_load();
        wait_drained();
        send_steady = 1'b0;
        recv_steady = 1'b0;

        // Random colors, and a long receiver hold-off while bytes keep coming
        load_colors($urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom_range(0, 15));
        send_random_load();
        hold_ask++;
        wait_drained();

        // Mixed extremes
        load_colors(4'h0, 4'hF, 4'hF, 4'h0);
        send_random_load();
        wait_drained();

        if (mismatches == 0)
            $display("ansi_color_escape_to_text_cells_top_tb passed");
        else
            $display("ansi_color_escape_to_text_cells_top_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/acet_pkg.sv
hdl/acet_in_if.sv
hdl/acet_out_if.sv
hdl/acet_cfg.sv
hdl/acet_ctrl.sv
hdl/acet_dp.sv
hdl/ansi_color_escape_to_text_cells_top.sv
hdl/acet_chk.sv
verif/ansi_color_escape_to_text_cells_top_tb.sv
